[rtl/raid5_block_read_reconstruct_macros.svh]
// Assertion macros shared by the RAID-5 read and reconstruct RTL.
`ifndef RAID5_BLOCK_READ_RECONSTRUCT_MACROS_SVH
`define RAID5_BLOCK_READ_RECONSTRUCT_MACROS_SVH
`ifndef SYNTH
// Check a property on every rising edge outside reset.
`define R5BR_CHECK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define R5BR_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define R5BR_CHECK(lbl, clk, rst, prop, msg)
`define R5BR_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

[rtl/r5br_pkg.sv]
// Types and constants of the RAID-5 block read and reconstruct unit.
`default_nettype none
package r5br_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int DIV_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DISKS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIPE_BLOCKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISK_WORDS    = 2'd2;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic        func;
    logic [2:0]  disk_id;
    logic [9:0]  word_offset;
    logic [31:0] word_data;
    logic [15:0] block_index;
  } r5br_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        unavailable;
  } r5br_res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PER, ST_LVL_GO, ST_LVL_WAIT, ST_LVLS_GO, ST_LVLS_WAIT, ST_CHECK,
    ST_COL_GO, ST_COL_WAIT, ST_MOD_GO, ST_MOD_WAIT, ST_MAP, ST_SEL,
    ST_RD_ISSUE, ST_RD_ACC, ST_FIN
  } r5br_state_t;

  typedef enum logic [1:0] {DIV_LVL, DIV_LVLS, DIV_COL, DIV_MOD} r5br_div_op_t;

  typedef struct packed {
    logic         per_ld;
    logic         div_start;
    r5br_div_op_t div_op;
    logic         map_ld;
    logic         walk_clr;
    logic         rd_issue;
    logic         acc_en;
    logic         walk_inc;
    logic         res_valid;
  } r5br_cmd_t;

  typedef struct packed {
    logic div_done;
    logic beyond;
    logic ddisk_present;
    logic missing_many;
    logic walk_last;
  } r5br_sts_t;

endpackage
`default_nettype wire

[rtl/r5br_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module r5br_div import r5br_pkg::*; #(
  parameter int W = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quot,
  output logic [W-1:0]      rem
);
  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt;
  logic [W-1:0]  dvs;
  logic [W:0]    shifted;
  logic          ge;

  assign shifted = {rem, quot[W-1]};
  assign ge      = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(W);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (cnt != '0) begin
      rem  <= ge ? W'(shifted - {1'b0, dvs}) : shifted[W-1:0];
      quot <= {quot[W-2:0], ge};
    end
  end
endmodule
`default_nettype wire

[rtl/r5br_datapath.sv]
// Datapath: configuration, disk store, address mapping and XOR accumulation.
`default_nettype none
`include "raid5_block_read_reconstruct_macros.svh"
module r5br_datapath import r5br_pkg::*; #(
  parameter int MAX_DISKS  = 8,
  parameter int DISK_WORDS = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire r5br_req_t             req,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire r5br_cmd_t             cmd,
  output r5br_sts_t                  sts,
  output logic                       result_valid,
  output r5br_res_t                  result
);
  localparam int NW = $clog2(MAX_DISKS + 1);
  localparam int DI = $clog2(MAX_DISKS);
  localparam int OW = (DISK_WORDS > 1) ? $clog2(DISK_WORDS) : 1;

  logic [3:0]  n_reg;
  logic [10:0] s_reg, dw_reg;
  logic [NW-1:0] n_eff;
  logic [10:0] s_eff, dw_eff;

  logic [15:0] idx, per, level, rem_lvl, levels, col, rcol, lmod;
  logic [MAX_DISKS-1:0] present;
  logic [31:0] mem [2**(DI+OW)];
  logic [31:0] rdata, acc;
  logic [DI-1:0] ddisk, walk_i;
  logic [OW-1:0] off;

  logic        div_done;
  logic [15:0] div_a, div_b, div_q, div_r;
  logic [NW:0] par, dsum;
  logic [26:0] off_full;
  logic [NW:0] miss_cnt;
  logic        unav, wr_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_reg  <= 4'd2;
      s_reg  <= 11'd1;
      dw_reg <= 11'd1024;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_DISKS:     n_reg  <= cfg_data[3:0];
        CFG_STRIPE_BLOCKS: s_reg  <= cfg_data;
        CFG_DISK_WORDS:    dw_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (n_reg < 4'd2) n_eff = NW'(2);
    else if (32'(n_reg) > MAX_DISKS) n_eff = NW'(MAX_DISKS);
    else n_eff = NW'(n_reg);
    s_eff  = (s_reg == '0) ? 11'd1 : s_reg;
    dw_eff = (32'(dw_reg) > DISK_WORDS) ? 11'(DISK_WORDS) : dw_reg;
  end

  // Store path: drop writes beyond the array.
  assign wr_ok = accept && (req.func == FUNC_WRITE) && (32'(req.disk_id) < MAX_DISKS)
                 && (32'(req.word_offset) < DISK_WORDS);

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
    end else if (wr_ok) begin
      present[DI'(req.disk_id)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[{DI'(req.disk_id), OW'(req.word_offset)}] <= req.word_data;
    end
    if (cmd.rd_issue) begin
      rdata <= mem[{walk_i, off}];
    end
  end

  always_comb begin
    unique case (cmd.div_op)
      DIV_LVL:  begin div_a = idx;           div_b = per;          end
      DIV_LVLS: begin div_a = 16'(dw_eff);   div_b = 16'(s_eff);   end
      DIV_COL:  begin div_a = rem_lvl;       div_b = 16'(s_eff);   end
      DIV_MOD:  begin div_a = level;         div_b = 16'(n_eff);   end
    endcase
  end

  r5br_div #(.W(DIV_W)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quot(div_q), .rem(div_r)
  );

  assign par      = (NW+1)'(n_eff) - 1'b1 - (NW+1)'(lmod);
  assign dsum     = par + (NW+1)'(col) + 1'b1;
  assign off_full = 27'(level) * 27'(s_eff) + 27'(rcol);

  always_comb begin
    miss_cnt = '0;
    for (int i = 0; i < MAX_DISKS; i++) begin
      if (i < int'(n_eff) && !present[i]) miss_cnt = miss_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) idx <= req.block_index;
    if (cmd.per_ld) per <= 16'((32'(n_eff) - 1) * 32'(s_eff));
    if (div_done) begin
      unique case (cmd.div_op)
        DIV_LVL:  begin level <= div_q; rem_lvl <= div_r; end
        DIV_LVLS: levels <= div_q;
        DIV_COL:  begin col <= div_q; rcol <= div_r; end
        DIV_MOD:  lmod <= div_r;
      endcase
    end
    if (cmd.map_ld) begin
      ddisk <= (dsum >= (NW+1)'(n_eff)) ? DI'(dsum - (NW+1)'(n_eff)) : DI'(dsum);
      off   <= OW'(off_full);
    end
    if (cmd.walk_clr) begin
      walk_i <= '0;
      acc    <= '0;
    end else begin
      if (cmd.acc_en && (sts.ddisk_present ? (walk_i == ddisk) : (walk_i != ddisk))) begin
        acc <= acc ^ rdata;
      end
      if (cmd.walk_inc) walk_i <= walk_i + 1'b1;
    end
  end

  assign sts.div_done      = div_done;
  assign sts.beyond        = level >= levels;
  assign sts.ddisk_present = present[ddisk];
  assign sts.missing_many  = miss_cnt > (NW+1)'(1);
  assign sts.walk_last     = 32'(walk_i) == 32'(n_eff) - 1;

  assign unav = sts.beyond || (!sts.ddisk_present && sts.missing_many);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_valid) begin
      result.unavailable <= unav;
      result.read_data   <= unav ? 32'd0 : acc;
    end
  end

  `R5BR_NEVER(a_walk_in_range, clk, rst, cmd.rd_issue && (32'(walk_i) >= 32'(n_eff)), "disk walk past array")
endmodule
`default_nettype wire

[rtl/r5br_ctrl.sv]
// Controller state machine sequencing the query steps.
`default_nettype none
module r5br_ctrl import r5br_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire logic      func,
  input  wire r5br_sts_t sts,
  output logic           busy,
  output r5br_cmd_t      cmd
);
  r5br_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_op = DIV_LVL;
    unique case (state)
      ST_IDLE: if (start && func == FUNC_QUERY) state_next = ST_PER;
      ST_PER: begin
        cmd.per_ld = 1'b1;
        state_next = ST_LVL_GO;
      end
      ST_LVL_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_LVL_WAIT;
      end
      ST_LVL_WAIT: if (sts.div_done) state_next = ST_LVLS_GO;
      ST_LVLS_GO: begin
        cmd.div_op    = DIV_LVLS;
        cmd.div_start = 1'b1;
        state_next    = ST_LVLS_WAIT;
      end
      ST_LVLS_WAIT: begin
        cmd.div_op = DIV_LVLS;
        if (sts.div_done) state_next = ST_CHECK;
      end
      ST_CHECK: state_next = sts.beyond ? ST_FIN : ST_COL_GO;
      ST_COL_GO: begin
        cmd.div_op    = DIV_COL;
        cmd.div_start = 1'b1;
        state_next    = ST_COL_WAIT;
      end
      ST_COL_WAIT: begin
        cmd.div_op = DIV_COL;
        if (sts.div_done) state_next = ST_MOD_GO;
      end
      ST_MOD_GO: begin
        cmd.div_op    = DIV_MOD;
        cmd.div_start = 1'b1;
        state_next    = ST_MOD_WAIT;
      end
      ST_MOD_WAIT: begin
        cmd.div_op = DIV_MOD;
        if (sts.div_done) state_next = ST_MAP;
      end
      ST_MAP: begin
        cmd.map_ld   = 1'b1;
        cmd.walk_clr = 1'b1;
        state_next   = ST_SEL;
      end
      ST_SEL: state_next = (!sts.ddisk_present && sts.missing_many) ? ST_FIN : ST_RD_ISSUE;
      ST_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_RD_ACC;
      end
      ST_RD_ACC: begin
        cmd.acc_en = 1'b1;
        if (sts.walk_last) begin
          state_next = ST_FIN;
        end else begin
          cmd.walk_inc = 1'b1;
          state_next   = ST_RD_ISSUE;
        end
      end
      ST_FIN: begin
        cmd.res_valid = 1'b1;
        state_next    = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = state != ST_IDLE;
endmodule
`default_nettype wire

[rtl/raid5_block_read_reconstruct.sv]
// Top level of the RAID-5 block read and reconstruct unit.
//
// Requests enter on req when start is high and busy is low. A write request
// (func 0) stores word_data into the disk store and marks the disk present in
// that same cycle; busy stays low, so writes may follow back to back and give
// no result. A query request (func 1) raises busy and yields exactly one
// result: result_valid is high for one cycle with read_data and unavailable.
// The receiver cannot hold results off; take each one on its strobe.
// A query makes four passes through the shared one-bit-per-cycle divider
// (stripe level, level count, stripe column, parity rotation), then one store
// read per disk in use over the single read port. A query past capacity stops
// after two passes; one whose block cannot be rebuilt skips the store reads.
// busy drops as the result register loads, so the next request may be taken
// in the cycle that the previous result is on the ports.
// Configuration writes use cfg_valid/cfg_ready (ready is always high); write
// them only while idle. Reset clears the present flags and loads the
// register defaults; the store contents stay undefined until written.
`default_nettype none
`include "raid5_block_read_reconstruct_macros.svh"
module raid5_block_read_reconstruct import r5br_pkg::*; #(
  parameter int MAX_DISKS  = 8,
  parameter int DISK_WORDS = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire r5br_req_t             req,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       result_valid,
  output r5br_res_t                  result
);
  r5br_cmd_t cmd;
  r5br_sts_t sts;
  logic      accept;
  logic      wr_take;
  logic      qry_take;

  // Hold config ready; the user must write config only while idle, the block does not enforce it.
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign wr_take   = accept && (req.func == FUNC_WRITE);
  assign qry_take  = accept && (req.func == FUNC_QUERY);

  r5br_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .func(req.func), .sts(sts), .busy(busy), .cmd(cmd)
  );

  r5br_datapath #(.MAX_DISKS(MAX_DISKS), .DISK_WORDS(DISK_WORDS)) u_dp (
    .clk(clk), .rst(rst), .accept(accept), .req(req),
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts), .result_valid(result_valid), .result(result)
  );

  `R5BR_CHECK(a_write_stays_idle, clk, rst, wr_take |=> !busy, "write left unit busy")
  `R5BR_CHECK(a_query_goes_busy, clk, rst, qry_take |=> busy, "query not started")
  `R5BR_CHECK(a_result_after_busy, clk, rst, result_valid |-> $past(busy), "result without query")
endmodule
`default_nettype wire
